// File: sv/mpm_pkg.sv
package mpm_pkg;

	// default geometry
	localparam int DEVICES_DEF   = 8;
	localparam int FRAME_LEN_DEF = 89;

	// input operations
	typedef enum logic [1:0] {
		OP_POLL = 2'd0,
		OP_RX   = 2'd1,
		OP_TICK = 2'd2,
		OP_READ = 2'd3
	} op_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_REQ     = 2'd0,
		KIND_STORED  = 2'd1,
		KIND_READ    = 2'd2,
		KIND_RESTART = 2'd3
	} kind_t;

	// configuration register indexes
	localparam logic [2:0] CFG_POLL_INTERVAL  = 3'd0;
	localparam logic [2:0] CFG_RESTART_LIMIT  = 3'd1;
	localparam logic [2:0] CFG_DEVICE_COUNT   = 3'd2;
	localparam logic [2:0] CFG_FUNCTION_CODE  = 3'd3;
	localparam logic [2:0] CFG_START_REGISTER = 3'd4;
	localparam logic [2:0] CFG_REGISTER_COUNT = 3'd5;
	localparam logic [2:0] CFG_FRAME_TIMEOUT  = 3'd6;

	// configuration reset values
	localparam logic [7:0]  RST_POLL_INTERVAL  = 8'd28;
	localparam logic [15:0] RST_RESTART_LIMIT  = 16'd1714;
	localparam logic [3:0]  RST_DEVICE_COUNT   = 4'd5;
	localparam logic [7:0]  RST_FUNCTION_CODE  = 8'h03;
	localparam logic [15:0] RST_START_REGISTER = 16'h0017;
	localparam logic [15:0] RST_REGISTER_COUNT = 16'h002A;
	localparam logic [7:0]  RST_FRAME_TIMEOUT  = 8'd2;

	// CRC-16/Modbus, reflected
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam int          CRC_MSG_BITS = 48;

	// CRC unit status
	typedef struct packed {
		logic        busy;
		logic [15:0] crc;
	} crc_stat_t;

endpackage

// File: sv/mpm_ram.sv
module mpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 89
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/mpm_crc.sv
module mpm_crc (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [47:0]               msg,
	output mpm_pkg::crc_stat_t        stat
);
	import mpm_pkg::*;

	logic [15:0] acc_q;
	logic [47:0] msg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        fb;

	// one message bit per cycle, bytes LSB first
	assign fb = acc_q[0] ^ msg_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= CRC_INIT;
			msg_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'(CRC_MSG_BITS - 1);
			acc_q  <= CRC_INIT;
			msg_q  <= msg;
		end else if (busy_q) begin
			acc_q <= fb ? ((acc_q >> 1) ^ CRC_POLY) : (acc_q >> 1);
			msg_q <= msg_q >> 1;
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.crc  = acc_q;

endmodule

// File: sv/modbus_poll_master.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-------------------------------------------
// input    | in_valid / in_ready       | operation, rx_byte, read_device, read_offset
// output   | out_valid / out_ready     | kind, data, last, device, fresh
// config   | cfg_we                    | cfg_index, cfg_data
//
// One item at a time. A poll tick with a request runs the bit-serial CRC unit, then
// the eight request bytes are sent. A frame commit copies one byte a cycle from the
// frame buffer RAM into the device store RAM. Store rows read as zero until their
// new-data flag is set, so no clearing pass follows reset. Frame buffer entries
// carry a valid bit, dropped when a full frame is judged. A stalled output holds
// the sequencer.
module modbus_poll_master #(
	parameter int DEVICES   = mpm_pkg::DEVICES_DEF,
	parameter int FRAME_LEN = mpm_pkg::FRAME_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           operation,
	input  logic [7:0]           rx_byte,
	input  logic [2:0]           read_device,
	input  logic [6:0]           read_offset,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mpm_pkg::kind_t       kind,
	output logic [7:0]           data,
	output logic                 last,
	output logic [3:0]           device,
	output logic                 fresh,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data
);
	import mpm_pkg::*;

	localparam int IDX_W    = $clog2(FRAME_LEN);
	localparam int ROW_W    = (DEVICES > 1) ? $clog2(DEVICES) : 1;
	localparam int DS_DEPTH = DEVICES * FRAME_LEN;
	localparam int DS_AW    = $clog2(DS_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_RESTART, S_CRC, S_REQ, S_FB_ADDR, S_COPY, S_COPY_END,
		S_STORED, S_RD_EMIT
	} state_t;

	state_t state_q;

	// configuration
	logic [7:0]  poll_interval_q, function_code_q, frame_timeout_q;
	logic [15:0] restart_limit_q, start_register_q, register_count_q;
	logic [3:0]  device_count_q;

	// poll and receive state
	logic [7:0]       poll_ticks_q, timer_ticks_q;
	logic [15:0]      restart_ticks_q;
	logic [3:0]       poll_address_q, req_addr_q, stored_dev_q;
	logic [IDX_W-1:0] rx_count_q, rd_idx_q, wr_idx_s1;
	logic             frame_full_q, timer_on_q, req_pend_q, wr_v_s1;
	logic             fresh_q;
	logic [47:0]      req_bytes_q;
	logic [2:0]       byte_q;
	logic [DS_AW-1:0] base_q;
	logic [ROW_W-1:0] row_q;
	logic [DEVICES-1:0] flags_q;

	// frame buffer entry valid bits; unwritten entries read as zero
	logic [FRAME_LEN-1:0] fb_vld_q;
	logic                 fb_vld_rd_q;
	logic [7:0]           fb_val;

	// output register
	logic        out_valid_q, out_last_q, out_fresh_q, out_load;
	kind_t       out_kind_q;
	logic [7:0]  out_data_q;
	logic [3:0]  out_dev_q;

	// memories and CRC
	logic             fb_we, fb_re, ds_we, ds_re;
	logic [IDX_W-1:0] fb_raddr;
	logic [7:0]       fb_rdata, ds_rdata;
	logic [DS_AW-1:0] ds_raddr, ds_waddr;
	logic             crc_start;
	logic [47:0]      crc_msg;
	crc_stat_t        crc_stat;

	// decode of the accepted item
	logic        acc, slot_free, rd_ok, restart_hit, req_hit, addr_ok;
	logic [15:0] rt_next;
	logic [7:0]  pt_next, tt_next;
	logic [3:0]  pa_next;
	logic [63:0] req_frame;

	assign in_ready  = (state_q == S_IDLE);
	assign acc       = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_load  = slot_free && ((state_q == S_RESTART) || (state_q == S_REQ) ||
		(state_q == S_STORED) || (state_q == S_RD_EMIT));

	assign rt_next     = restart_ticks_q + 16'd1;
	assign restart_hit = rt_next > restart_limit_q;
	assign pt_next     = poll_ticks_q + 8'd1;
	assign req_hit     = pt_next == poll_interval_q;
	assign pa_next     = poll_address_q + 4'd1;
	assign tt_next     = timer_ticks_q + 8'd1;
	assign crc_msg     = {register_count_q[7:0], register_count_q[15:8],
		start_register_q[7:0], start_register_q[15:8], function_code_q,
		4'd0, pa_next};
	assign crc_start   = acc && (operation == OP_POLL) && req_hit;
	assign req_frame   = {crc_stat.crc, req_bytes_q};

	assign fb_val  = fb_vld_rd_q ? fb_rdata : 8'd0;
	assign rd_ok   = (int'(read_device) < DEVICES) && (int'(read_offset) < FRAME_LEN);
	assign addr_ok = (fb_val != 8'd0) && (int'(fb_val) <= DEVICES);

	// frame buffer ports
	assign fb_we    = acc && (operation == OP_RX);
	assign fb_re    = (acc && (operation == OP_TICK)) || (state_q == S_COPY);
	assign fb_raddr = (state_q == S_COPY) ? rd_idx_q : '0;

	// device store ports
	assign ds_we    = wr_v_s1;
	assign ds_waddr = base_q + DS_AW'(wr_idx_s1);
	assign ds_re    = acc && (operation == OP_READ) && rd_ok;
	assign ds_raddr = DS_AW'(int'(read_device) * FRAME_LEN + int'(read_offset));

	mpm_ram #(.WIDTH(8), .DEPTH(FRAME_LEN)) u_fb_ram (
		.clk  (clk),
		.we   (fb_we),
		.waddr(rx_count_q),
		.wdata(rx_byte),
		.re   (fb_re),
		.raddr(fb_raddr),
		.rdata(fb_rdata)
	);

	mpm_ram #(.WIDTH(8), .DEPTH(DS_DEPTH)) u_ds_ram (
		.clk  (clk),
		.we   (ds_we),
		.waddr(ds_waddr),
		.wdata(fb_val),
		.re   (ds_re),
		.raddr(ds_raddr),
		.rdata(ds_rdata)
	);

	mpm_crc u_crc (
		.clk   (clk),
		.arst_n(arst_n),
		.start (crc_start),
		.msg   (crc_msg),
		.stat  (crc_stat)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_interval_q  <= RST_POLL_INTERVAL;
			restart_limit_q  <= RST_RESTART_LIMIT;
			device_count_q   <= RST_DEVICE_COUNT;
			function_code_q  <= RST_FUNCTION_CODE;
			start_register_q <= RST_START_REGISTER;
			register_count_q <= RST_REGISTER_COUNT;
			frame_timeout_q  <= RST_FRAME_TIMEOUT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POLL_INTERVAL:  poll_interval_q  <= cfg_data[7:0];
				CFG_RESTART_LIMIT:  restart_limit_q  <= cfg_data;
				CFG_DEVICE_COUNT:   device_count_q   <= cfg_data[3:0];
				CFG_FUNCTION_CODE:  function_code_q  <= cfg_data[7:0];
				CFG_START_REGISTER: start_register_q <= cfg_data;
				CFG_REGISTER_COUNT: register_count_q <= cfg_data;
				CFG_FRAME_TIMEOUT:  frame_timeout_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			poll_ticks_q    <= '0;
			restart_ticks_q <= '0;
			poll_address_q  <= '0;
			req_addr_q      <= '0;
			rx_count_q      <= '0;
			frame_full_q    <= 1'b0;
			timer_on_q      <= 1'b0;
			timer_ticks_q   <= '0;
			req_pend_q      <= 1'b0;
			req_bytes_q     <= '0;
			byte_q          <= '0;
			rd_idx_q        <= '0;
			wr_idx_s1       <= '0;
			wr_v_s1         <= 1'b0;
			base_q          <= '0;
			row_q           <= '0;
			stored_dev_q    <= '0;
			fresh_q         <= 1'b0;
			flags_q         <= '0;
			fb_vld_q        <= '0;
			fb_vld_rd_q     <= 1'b0;
			out_valid_q     <= 1'b0;
			out_kind_q      <= KIND_REQ;
			out_data_q      <= '0;
			out_last_q      <= 1'b0;
			out_dev_q       <= '0;
			out_fresh_q     <= 1'b0;
		end else begin
			if (out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			wr_v_s1   <= (state_q == S_COPY);
			wr_idx_s1 <= rd_idx_q;
			// valid bit travels with the registered read data
			if (fb_re) begin
				fb_vld_rd_q <= fb_vld_q[fb_raddr];
			end

			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (operation)
							OP_POLL: begin
								restart_ticks_q <= restart_hit ? 16'd0 : rt_next;
								poll_ticks_q    <= req_hit ? 8'd0 : pt_next;
								req_pend_q      <= req_hit;
								if (req_hit) begin
									req_addr_q     <= pa_next;
									req_bytes_q    <= crc_msg;
									poll_address_q <= (pa_next >= device_count_q) ?
										4'd0 : pa_next;
								end
								if (restart_hit) begin
									state_q <= S_RESTART;
								end else if (req_hit) begin
									state_q <= S_CRC;
								end
							end
							OP_RX: begin
								fb_vld_q[rx_count_q] <= 1'b1;
								if (rx_count_q == '0) begin
									timer_on_q <= 1'b1;
								end
								if (rx_count_q == LAST_IDX) begin
									rx_count_q   <= '0;
									frame_full_q <= 1'b1;
								end else begin
									rx_count_q <= rx_count_q + IDX_W'(1);
								end
							end
							OP_TICK: begin
								if (timer_on_q) begin
									if (tt_next == frame_timeout_q) begin
										timer_ticks_q <= '0;
										timer_on_q    <= 1'b0;
										frame_full_q  <= 1'b0;
										if (frame_full_q) begin
											state_q <= S_FB_ADDR;
										end else begin
											rx_count_q <= '0;
										end
									end else begin
										timer_ticks_q <= tt_next;
									end
								end
							end
							default: begin
								fresh_q <= rd_ok && flags_q[ROW_W'(read_device)];
								state_q <= S_RD_EMIT;
							end
						endcase
					end
				end
				S_RESTART: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_RESTART;
						out_data_q  <= '0;
						out_last_q  <= !req_pend_q;
						out_dev_q   <= '0;
						out_fresh_q <= 1'b0;
						state_q     <= req_pend_q ? S_CRC : S_IDLE;
					end
				end
				S_CRC: begin
					if (!crc_stat.busy) begin
						byte_q  <= '0;
						state_q <= S_REQ;
					end
				end
				S_REQ: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_REQ;
						out_data_q  <= req_frame[{byte_q, 3'b000} +: 8];
						out_last_q  <= (byte_q == 3'd7);
						out_dev_q   <= req_addr_q;
						out_fresh_q <= 1'b0;
						byte_q      <= byte_q + 3'd1;
						if (byte_q == 3'd7) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_FB_ADDR: begin
					// address byte of the frame is on the read port now
					if (addr_ok) begin
						row_q        <= ROW_W'(fb_val - 8'd1);
						base_q       <= DS_AW'(int'(fb_val - 8'd1) * FRAME_LEN);
						stored_dev_q <= fb_val[3:0];
						rd_idx_q     <= '0;
						state_q      <= S_COPY;
					end else begin
						// dropped frame still empties the buffer
						fb_vld_q <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_COPY: begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
					if (rd_idx_q == LAST_IDX) begin
						state_q <= S_COPY_END;
					end
				end
				S_COPY_END: begin
					fb_vld_q <= '0;
					state_q  <= S_STORED;
				end
				S_STORED: begin
					if (slot_free) begin
						flags_q[row_q] <= 1'b1;
						out_valid_q    <= 1'b1;
						out_kind_q     <= KIND_STORED;
						out_data_q     <= '0;
						out_last_q     <= 1'b1;
						out_dev_q      <= stored_dev_q;
						out_fresh_q    <= 1'b0;
						state_q        <= S_IDLE;
					end
				end
				S_RD_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_READ;
						out_data_q  <= fresh_q ? ds_rdata : 8'd0;
						out_last_q  <= 1'b1;
						out_dev_q   <= '0;
						out_fresh_q <= fresh_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = out_kind_q;
	assign data      = out_data_q;
	assign last      = out_last_q;
	assign device    = out_dev_q;
	assign fresh     = out_fresh_q;

	// a read item goes straight to its result state
	a_read_flow: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (operation == OP_READ) |=> state_q == S_RD_EMIT)
		else $error("read item did not reach result state");

	// store writes only come from the copy sweep
	a_copy_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_v_s1 |-> (state_q == S_COPY) || (state_q == S_COPY_END))
		else $error("device store written outside copy");

	// a stored frame always names a device in range
	a_stored_dev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_kind_q == KIND_STORED) |->
		(out_dev_q != 4'd0) && (int'(out_dev_q) <= DEVICES))
		else $error("stored frame with bad device");

	// request bytes are only sent once the CRC is settled
	a_req_crc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_REQ |-> !crc_stat.busy)
		else $error("request sent while CRC busy");

endmodule
